FILE: rtl/sensor_response_crc_decoder_core_macros.svh
// Assertion macros for the decoder RTL; srcd_back.sv is the only file that uses them.
`ifndef SENSOR_RESPONSE_CRC_DECODER_CORE_MACROS_SVH
`define SENSOR_RESPONSE_CRC_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SRCD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srcd assertion failed");
`define SRCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srcd assertion failed");
`else
`define SRCD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SRCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/srcd_pkg.sv
// Shared types, constants and the CRC-8 update for the response decoder.
package srcd_pkg;

    localparam int WORDS_PER_FRAME = 3;
    localparam int WORD_IDX_W      = $clog2(WORDS_PER_FRAME);

    localparam logic [WORD_IDX_W-1:0] CO2_WORD  = WORD_IDX_W'(0);
    localparam logic [WORD_IDX_W-1:0] TEMP_WORD = WORD_IDX_W'(1);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS_PER_FRAME - 1);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte phase within one word
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    // Configuration register indexes
    localparam logic REG_CO2_MIN = 1'b0;
    localparam logic REG_CO2_MAX = 1'b1;

    localparam logic [15:0] CO2_MIN_RESET = 16'd400;
    localparam logic [15:0] CO2_MAX_RESET = 16'd5000;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        err;
        logic [15:0] co2;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } t_task;

    typedef struct packed {
        logic [15:0] co2_min;
        logic [15:0] co2_max;
    } t_window;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/srcd_front.sv
// Byte parser: frame tracking, per-word CRC check and task generation.
module srcd_front import srcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_full,
    output logic       o_push,
    output t_task      o_task
);

    logic [1:0]            r_phase, n_phase;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic                  r_skip, n_skip;
    logic [7:0]            r_crc, n_crc;
    logic [7:0]            r_hi, n_hi;
    logic [7:0]            r_lo, n_lo;
    logic [15:0]           r_co2, n_co2;
    logic [15:0]           r_temp, n_temp;

    logic                  accept;
    logic [1:0]            cur_phase;
    logic [WORD_IDX_W-1:0] cur_word;
    logic [15:0]           word_val;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign cur_phase = i_start ? PH_HIGH : r_phase;
    assign cur_word  = i_start ? '0 : r_word;
    assign word_val  = {r_hi, r_lo};

    always_comb begin
        n_phase = r_phase;
        n_word  = r_word;
        n_skip  = r_skip;
        n_crc   = r_crc;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_co2   = r_co2;
        n_temp  = r_temp;
        o_push  = 1'b0;
        o_task  = '0;
        if (accept && (i_start || !r_skip)) begin
            n_skip  = 1'b0;
            n_phase = cur_phase;
            n_word  = cur_word;
            unique case (cur_phase)
                PH_HIGH: begin
                    n_crc   = crc8_update(CRC_INIT, i_byte);
                    n_hi    = i_byte;
                    n_phase = PH_LOW;
                end
                PH_LOW: begin
                    n_crc   = crc8_update(r_crc, i_byte);
                    n_lo    = i_byte;
                    n_phase = PH_CRC;
                end
                PH_CRC: begin
                    if (r_crc != i_byte) begin
                        // Report at once, then drop bytes until the next start
                        o_push     = 1'b1;
                        o_task.err = 1'b1;
                        n_skip     = 1'b1;
                        n_phase    = PH_HIGH;
                        n_word     = '0;
                    end else if (cur_word == LAST_WORD) begin
                        o_push          = 1'b1;
                        o_task.co2      = r_co2;
                        o_task.temp_raw = r_temp;
                        o_task.hum_raw  = word_val;
                        n_skip          = 1'b1;
                        n_phase         = PH_HIGH;
                        n_word          = '0;
                    end else begin
                        if (cur_word == CO2_WORD) begin
                            n_co2 = word_val;
                        end
                        if (cur_word == TEMP_WORD) begin
                            n_temp = word_val;
                        end
                        n_word  = cur_word + WORD_IDX_W'(1);
                        n_phase = PH_HIGH;
                    end
                end
                default: begin
                    n_phase = PH_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HIGH;
            r_word  <= '0;
            r_skip  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_word  <= n_word;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_co2  <= n_co2;
        r_temp <= n_temp;
    end

endmodule

FILE: rtl/srcd_fifo.sv
// Short task queue between the parser and the conversion pipeline.
module srcd_fifo import srcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_task o_task
);

    t_task                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push, do_pop;

    assign o_full     = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_task     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

endmodule

FILE: rtl/srcd_back.sv
// Conversion pipeline: scale multiply, divide by 65535, window check, output register.
`include "sensor_response_crc_decoder_core_macros.svh"
module srcd_back import srcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    input  t_task              i_task,
    output logic               o_pop,
    input  t_window            i_window,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_co2,
    output logic signed [14:0] o_temp,
    output logic [13:0]        o_hum,
    output logic               o_reading_valid,
    output logic               o_err
);

    logic        r_a_valid;
    logic        r_a_err;
    logic [15:0] r_a_co2;
    logic [30:0] r_a_tmul;
    logic [29:0] r_a_hmul;
    logic        r_a_inwin;

    logic        r_out_valid;
    logic [15:0] r_out_co2;
    logic [14:0] r_out_temp;
    logic [13:0] r_out_hum;
    logic        r_out_rv;
    logic        r_out_err;

    logic        advance, a_load;
    logic [31:0] t_sum;
    logic [30:0] h_sum;
    logic [14:0] t_q;
    logic [13:0] h_q;

    assign advance = !r_out_valid || i_ready;
    assign a_load  = !r_a_valid || advance;
    assign o_pop   = i_task_valid && a_load;

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 2^32
    assign t_sum = {1'b0, r_a_tmul} + 32'(r_a_tmul[30:16]) + 32'd1;
    assign h_sum = {1'b0, r_a_hmul} + 31'(r_a_hmul[29:16]) + 31'd1;
    assign t_q   = t_sum[30:16];
    assign h_q   = h_sum[29:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_valid <= i_task_valid;
            end
            if (advance) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_err   <= i_task.err;
            r_a_co2   <= i_task.co2;
            r_a_tmul  <= 31'(TEMP_SCALE) * 31'(i_task.temp_raw);
            r_a_hmul  <= 30'(HUM_SCALE) * 30'(i_task.hum_raw);
            r_a_inwin <= (i_task.co2 >= i_window.co2_min) && (i_task.co2 <= i_window.co2_max);
        end
        if (advance && r_a_valid) begin
            // Zero every data field of an error item; the error flag itself is kept
            r_out_err  <= r_a_err;
            r_out_co2  <= r_a_err ? '0 : r_a_co2;
            r_out_temp <= r_a_err ? '0 : (t_q - TEMP_OFFSET);
            r_out_hum  <= r_a_err ? '0 : h_q;
            r_out_rv   <= r_a_err ? 1'b0 : r_a_inwin;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_co2           = r_out_co2;
    assign o_temp          = r_out_temp;
    assign o_hum           = r_out_hum;
    assign o_reading_valid = r_out_rv;
    assign o_err           = r_out_err;

    `SRCD_ASSERT_IMPLIES(a_err_fields_zero, i_clk, i_rst_n, r_out_valid && r_out_err, (r_out_co2 == '0) && (r_out_hum == '0) && (r_out_temp == '0) && !r_out_rv)
    `SRCD_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_a_valid && !advance, r_a_valid && $stable(r_a_tmul))
    `SRCD_ASSERT_IMPLIES(a_no_pop_when_blocked, i_clk, i_rst_n, r_a_valid && !advance, !o_pop)

endmodule

FILE: rtl/sensor_response_crc_decoder_core.sv
// Top level of the CRC-checked sensor response decoder.
//
//  channel  | direction | handshake                      | content
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata rx_byte, tuser frame_start
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata reading, tuser crc_error
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while s_axis_tready is high; after its last byte a result
// passes the task queue, the scaling multiply stage and the divide and output register.
// i_rst_n is synchronous, active low: window registers reload 400 and 5000, queue
// and pipeline empty, and the parser waits for a frame start.
// s_axis_tready drops only when the two-entry task queue is full, which happens
// only while m_axis_tready is held low.
module sensor_response_crc_decoder_core import srcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] co2_ppm, [30:16] temperature_centi_c,
                                        // [44:31] humidity_centi_pct, [45] reading_valid,
                                        // [47:46] zero
    output logic        m_axis_tuser,   // [0] crc_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_window            r_window;
    logic               push, full, nonempty, pop;
    t_task              push_task, head_task;
    logic [15:0]        co2;
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic               reading_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window.co2_min <= CO2_MIN_RESET;
            r_window.co2_max <= CO2_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CO2_MIN: r_window.co2_min <= i_cfg_data;
                REG_CO2_MAX: r_window.co2_max <= i_cfg_data;
                default:     r_window         <= r_window;
            endcase
        end
    end

    srcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_task  (push_task)
    );

    srcd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_task     (push_task),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_task     (head_task)
    );

    srcd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_task_valid    (nonempty),
        .i_task          (head_task),
        .o_pop           (pop),
        .i_window        (r_window),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_co2           (co2),
        .o_temp          (temp),
        .o_hum           (hum),
        .o_reading_valid (reading_valid),
        .o_err           (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, reading_valid, hum, temp, co2};

endmodule

FILE: sim/sensor_response_crc_decoder_core_checker.sv
// Checker for the response decoder: predicts readings from accepted bytes and compares results.
`timescale 1ns / 1ps

module sensor_response_crc_decoder_core_checker import srcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_start,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic        i_out_err,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_mismatches,
    output int          o_readings,
    output int          o_crc_errors
);

    localparam int FRAME_BYTES = WORDS_PER_FRAME * 3;

    typedef struct packed {
        logic [15:0] co2;
        logic [14:0] temp;
        logic [13:0] hum;
        logic        in_window;
        logic        crc_err;
    } t_reading;

    t_reading    expected_readings[$];

    logic [15:0] window_min;
    logic [15:0] window_max;

    logic [3:0]  byte_pos;
    logic [7:0]  running_crc;
    logic [7:0]  high_hold;
    logic [7:0]  low_hold;
    logic [15:0] co2_hold;
    logic [15:0] temp_hold;
    logic        waiting_start;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_readings   = 0;
        o_crc_errors = 0;
    end

    // Bit-serial form: feed one data bit per shift, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] decoder mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             o_readings, name, got, want));
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic st);
        logic [1:0]            phase;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [15:0]           word;
        logic [31:0]           t_scaled;
        logic [31:0]           h_scaled;
        logic [31:0]           temp_full;
        t_reading              r;
        if (st) begin
            waiting_start = 1'b0;
            byte_pos      = '0;
        end
        if (waiting_start)
            return;
        // drop trailing bytes of a finished frame
        if (byte_pos >= FRAME_BYTES) begin
            waiting_start = 1'b1;
            return;
        end
        phase    = 2'(byte_pos % 3);
        word_idx = WORD_IDX_W'(byte_pos / 3);
        if (phase == PH_HIGH) begin
            running_crc = crc8_step(CRC_INIT, b);
            high_hold   = b;
            byte_pos++;
        end else if (phase == PH_LOW) begin
            running_crc = crc8_step(running_crc, b);
            low_hold    = b;
            byte_pos++;
        end else if (running_crc != b) begin
            waiting_start = 1'b1;
            byte_pos      = '0;
            r             = '0;
            r.crc_err     = 1'b1;
            expected_readings.push_back(r);
        end else begin
            word = {high_hold, low_hold};
            if (word_idx == CO2_WORD)
                co2_hold = word;
            else if (word_idx == TEMP_WORD)
                temp_hold = word;
            byte_pos++;
            if (byte_pos == FRAME_BYTES) begin
                t_scaled    = (32'(TEMP_SCALE) * 32'(temp_hold)) / 32'd65535;
                h_scaled    = (32'(HUM_SCALE) * 32'(word)) / 32'd65535;
                temp_full   = t_scaled - 32'(TEMP_OFFSET);
                r.co2       = co2_hold;
                r.temp      = temp_full[14:0];
                r.hum       = h_scaled[13:0];
                r.in_window = (co2_hold >= window_min) && (co2_hold <= window_max);
                r.crc_err   = 1'b0;
                expected_readings.push_back(r);
                waiting_start = 1'b1;
                byte_pos      = '0;
            end
        end
    endtask

    task automatic check_result();
        t_reading want;
        if (expected_readings.size() == 0) begin
            report($sformatf("result with nothing expected: data 0x%0h, crc_error %0b",
                             i_out_data, i_out_err));
        end else begin
            want = expected_readings.pop_front();
            check_field("co2_ppm", i_out_data[15:0], want.co2);
            check_field("temperature_centi_c", 16'(i_out_data[30:16]), 16'(want.temp));
            check_field("humidity_centi_pct", 16'(i_out_data[44:31]), 16'(want.hum));
            check_field("reading_valid", 16'(i_out_data[45]), 16'(want.in_window));
            check_field("pad bits", 16'(i_out_data[47:46]), 16'h0000);
            check_field("crc_error", 16'(i_out_err), 16'(want.crc_err));
            if (want.crc_err)
                o_crc_errors++;
        end
        o_readings++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_min    = CO2_MIN_RESET;
            window_max    = CO2_MAX_RESET;
            byte_pos      = '0;
            running_crc   = CRC_INIT;
            high_hold     = '0;
            low_hold      = '0;
            co2_hold      = '0;
            temp_hold     = '0;
            waiting_start = 1'b1;
            expected_readings.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_CO2_MIN)
                    window_min = i_cfg_data;
                else
                    window_max = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_byte, i_in_start);
        end
        o_pending <= expected_readings.size();
    end

endmodule

FILE: sim/sensor_response_crc_decoder_core_test.sv
// Stimulus and verdict for the response decoder: framed byte streams under several windows.
`timescale 1ns / 1ps

module sensor_response_crc_decoder_core_test;
    import srcd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 5;
    localparam int PHASE_BYTES  = 85;
    localparam int NO_BAD_WORD  = WORDS_PER_FRAME;
    localparam int FRAME_BYTES  = WORDS_PER_FRAME * 3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_index   = REG_CO2_MIN;
    logic [15:0] i_cfg_data    = 16'h0000;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        o_cfg_ready;

    int          pending;
    int          mismatches;
    int          readings;
    int          crc_errors;

    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    int          stall_hold  = 0;
    int          cycles      = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    logic [15:0] win_min     = CO2_MIN_RESET;
    logic [15:0] win_max     = CO2_MAX_RESET;

    sensor_response_crc_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sensor_response_crc_decoder_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_start   (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_err    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_readings   (readings),
        .o_crc_errors (crc_errors)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("sensor_response_crc_decoder_core_test: FAIL");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!stalls_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            stall_hold    <= idle_len();
        end
    end

    // Called at a clock edge; returns at the edge that accepts the item
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Send the first cut bytes of a frame; bad_word selects a word whose CRC is corrupted
    task automatic send_frame(input logic [15:0] co2, input logic [15:0] temp,
                              input logic [15:0] hum, input int bad_word, input int cut);
        logic [15:0] words [WORDS_PER_FRAME];
        logic [7:0]  fb [FRAME_BYTES];
        logic [7:0]  crc;
        words[0] = co2;
        words[1] = temp;
        words[2] = hum;
        for (int w = 0; w < WORDS_PER_FRAME; w++) begin
            crc = crc8_update(crc8_update(CRC_INIT, words[w][15:8]), words[w][7:0]);
            if (w == bad_word)
                crc ^= 8'($urandom_range(1, 255));
            fb[3*w]     = words[w][15:8];
            fb[3*w + 1] = words[w][7:0];
            fb[3*w + 2] = crc;
        end
        for (int i = 0; i < cut; i++)
            send_byte(fb[i], i == 0);
        frames_sent++;
        bytes_sent += cut;
    endtask

    function automatic logic [15:0] pick_word(input bit near_window);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        else if (r == 1)
            return 16'hFFFF;
        else if (near_window && r < 4)
            return win_min + 16'($urandom_range(0, 2)) - 16'd1;
        else if (near_window && r < 6)
            return win_max + 16'($urandom_range(0, 2)) - 16'd1;
        else
            return 16'($urandom);
    endfunction

    task automatic write_window(input logic [15:0] lo, input logic [15:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_CO2_MIN;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_CO2_MAX;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_min = lo;
        win_max = hi;
    endtask

    // Drop valid, wait for every expected result, then let the pipeline drain
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          kind;
        int          phase_start;
        logic [15:0] v;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray bytes before any frame start
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(CO2_MIN_RESET, 16'h0000, 16'hFFFF, NO_BAD_WORD, FRAME_BYTES);
        send_byte(8'hA5, 1'b0);
        // restart in the middle of a frame
        send_frame(CO2_MAX_RESET, 16'hFFFF, 16'h8000, NO_BAD_WORD, 4);
        send_frame(CO2_MAX_RESET + 16'd1, 16'hFFFF, 16'h0000, NO_BAD_WORD, FRAME_BYTES);
        send_frame(CO2_MIN_RESET - 16'd1, 16'h1234, 16'h5678, 0, 3);
        send_byte(8'h5A, 1'b0);
        finish_phase();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    gaps_on   = 1'b1;
                    stalls_on = 1'b1;
                end
                1: begin
                    write_window(16'h0000, 16'hFFFF);
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                2: begin
                    write_window(16'hFFFF, 16'h0000);
                    gaps_on   = 1'b1;
                    stalls_on = 1'b0;
                end
                3: begin
                    v = 16'($urandom);
                    write_window(v, v);
                    gaps_on   = 1'b0;
                    stalls_on = 1'b1;
                end
                default: begin
                    write_window(16'($urandom), 16'($urandom));
                    gaps_on   = 1'b1;
                    stalls_on = 1'b1;
                end
            endcase

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    send_frame(pick_word(1'b1), pick_word(1'b0), pick_word(1'b0),
                               NO_BAD_WORD, FRAME_BYTES);
                end else if (kind < 80) begin
                    send_frame(pick_word(1'b1), pick_word(1'b0), pick_word(1'b0),
                               $urandom_range(0, WORDS_PER_FRAME - 1), FRAME_BYTES);
                end else if (kind < 90) begin
                    send_frame(pick_word(1'b1), pick_word(1'b0), pick_word(1'b0),
                               NO_BAD_WORD, $urandom_range(1, FRAME_BYTES - 1));
                end else begin
                    // noise, now and then with a start flag that opens a garbage frame
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
            end
            finish_phase();
        end

        $display("covered %0d frame bytes in %0d frames under %0d CO2 windows",
                 bytes_sent, frames_sent, PHASES);
        $display("checked %0d results, %0d of them CRC errors", readings, crc_errors);
        if (mismatches == 0) begin
            $display("sensor_response_crc_decoder_core_test: PASS");
        end else begin
            $display("sensor_response_crc_decoder_core_test: FAIL");
        end
        $finish;
    end

endmodule
